// ===== hw/rtl/ahc_pkg.sv =====
// Package for the alarm and hourly chime block: beat types, config set,
// phase codes, register indexes and tick counts.
// No dependencies.
`timescale 1ns / 1ps

package ahc_pkg;

  // tick counts for the two countdowns
  localparam logic [15:0] ALARM_TICKS = 16'd600;
  localparam logic [7:0]  CHIME_TICKS = 8'd20;

  // register map
  localparam int          REG_AW = 3;
  localparam int          PADDR_W = REG_AW + 2;
  localparam logic [REG_AW-1:0] REG_ALARM_HOUR       = 3'd0;
  localparam logic [REG_AW-1:0] REG_ALARM_MINUTE     = 3'd1;
  localparam logic [REG_AW-1:0] REG_ALARM_ENABLE     = 3'd2;
  localparam logic [REG_AW-1:0] REG_CHIME_ENABLE     = 3'd3;
  localparam logic [REG_AW-1:0] REG_CHIME_START_HOUR = 3'd4;
  localparam logic [REG_AW-1:0] REG_CHIME_STOP_HOUR  = 3'd5;

  // reset value of the chime window end
  localparam logic [4:0] CHIME_STOP_RESET = 5'd23;

  typedef enum logic [1:0] {
    PH_ARMED   = 2'd0,
    PH_RINGING = 2'd1,
    PH_DONE    = 2'd2
  } ahc_phase_t;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       key_pressed;
  } ahc_in_t;

  typedef struct packed {
    logic buzzer_on;
    logic alarm_ringing;
    logic chime_ringing;
  } ahc_out_t;

  typedef struct packed {
    logic [4:0] wake_hour;
    logic [5:0] wake_minute;
    logic       alarm_enable;
    logic       chime_enable;
    logic [4:0] chime_start_hour;
    logic [4:0] chime_stop_hour;
  } ahc_cfg_t;

endpackage

// ===== hw/rtl/ahc_seq.sv =====
// Alarm and chime sequencer state: phases, countdowns and request count,
// advanced by one tick per step. Result is the post-tick status.
// Depends on ahc_pkg.
`timescale 1ns / 1ps

module ahc_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ahc_pkg::ahc_in_t  item,
  input  ahc_pkg::ahc_cfg_t cfg,
  output ahc_pkg::ahc_out_t res
);
  import ahc_pkg::*;

  ahc_phase_t  alarm_phase, alarm_phase_next;
  logic [15:0] alarm_remaining, alarm_remaining_next;
  ahc_phase_t  chime_phase, chime_phase_next;
  logic [7:0]  chime_remaining, chime_remaining_next;
  logic [1:0]  sound_requests, sound_requests_next;

  logic        skip_chime;
  logic        in_window;
  logic        a_up, a_down, c_up, c_down;
  logic [15:0] alarm_dec;
  logic [7:0]  chime_dec;

  // chime hour window, wrapping past midnight when start > stop
  always_comb begin
    if (cfg.chime_start_hour <= cfg.chime_stop_hour) begin
      in_window = (cfg.chime_start_hour <= item.hour_now) &&
                  (item.hour_now <= cfg.chime_stop_hour);
    end else begin
      in_window = (cfg.chime_start_hour <= item.hour_now) ||
                  (item.hour_now <= cfg.chime_stop_hour);
    end
  end

  // saturating countdown steps
  assign alarm_dec = (alarm_remaining != '0) ? alarm_remaining - 16'd1 : '0;
  assign chime_dec = (chime_remaining != '0) ? chime_remaining - 8'd1 : '0;

  // alarm phase
  always_comb begin
    alarm_phase_next     = alarm_phase;
    alarm_remaining_next = alarm_remaining;
    a_up                 = 1'b0;
    a_down               = 1'b0;
    skip_chime           = 1'b0;
    unique case (alarm_phase)
      PH_RINGING: begin
        if (item.key_pressed) begin
          alarm_phase_next     = PH_DONE;
          alarm_remaining_next = '0;
          a_down               = 1'b1;
          skip_chime           = 1'b1;
        end else begin
          alarm_remaining_next = alarm_dec;
          if (alarm_dec == '0) begin
            alarm_phase_next = PH_DONE;
            a_down           = 1'b1;
          end
        end
      end
      PH_DONE: begin
        if (cfg.wake_hour != item.hour_now) begin
          alarm_phase_next = PH_ARMED;
        end
      end
      default: begin
        alarm_phase_next = PH_ARMED;
        if (cfg.alarm_enable && (cfg.wake_hour == item.hour_now) &&
            (cfg.wake_minute == item.minute_now)) begin
          alarm_phase_next     = PH_RINGING;
          alarm_remaining_next = ALARM_TICKS;
          a_up                 = 1'b1;
        end
      end
    endcase
  end

  // chime phase, held when a key silences the alarm
  always_comb begin
    chime_phase_next     = chime_phase;
    chime_remaining_next = chime_remaining;
    c_up                 = 1'b0;
    c_down               = 1'b0;
    if (!skip_chime) begin
      unique case (chime_phase)
        PH_RINGING: begin
          chime_remaining_next = chime_dec;
          if (chime_dec == '0) begin
            chime_phase_next = PH_DONE;
            c_down           = 1'b1;
          end
        end
        PH_DONE: begin
          if (item.minute_now != '0) begin
            chime_phase_next = PH_ARMED;
          end
        end
        default: begin
          chime_phase_next = PH_ARMED;
          if (cfg.chime_enable && (item.minute_now == '0) &&
              (item.second_now == '0) && in_window) begin
            chime_phase_next     = PH_RINGING;
            chime_remaining_next = CHIME_TICKS;
            c_up                 = 1'b1;
          end
        end
      endcase
    end
  end

  // request count, modulo four
  assign sound_requests_next = sound_requests + {1'b0, a_up} + {1'b0, c_up}
                               - {1'b0, a_down} - {1'b0, c_down};

  // post-tick status
  assign res.buzzer_on     = (sound_requests_next != '0);
  assign res.alarm_ringing = (alarm_phase_next == PH_RINGING);
  assign res.chime_ringing = (chime_phase_next == PH_RINGING);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_phase     <= PH_ARMED;
      alarm_remaining <= '0;
      chime_phase     <= PH_ARMED;
      chime_remaining <= '0;
      sound_requests  <= '0;
    end else if (step) begin
      alarm_phase     <= alarm_phase_next;
      alarm_remaining <= alarm_remaining_next;
      chime_phase     <= chime_phase_next;
      chime_remaining <= chime_remaining_next;
      sound_requests  <= sound_requests_next;
    end
  end

endmodule

// ===== hw/rtl/alarm_and_hourly_chime.sv =====
// Alarm and hourly chime: tick input register, sequencer and result register.
// Each tick is held in the input register until the result register is free.
// Throughput: one tick per cycle while the result side takes every result.
// An empty input register takes a new beat while a result waits to be taken.
// Reset (rst, synchronous, active high) arms both sequencers, clears the
// countdowns and request count, and loads the register reset values.
`timescale 1ns / 1ps

module alarm_and_hourly_chime (
  input  logic                         clk,
  input  logic                         rst,
  // tick channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ahc_pkg::ahc_in_t             in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output ahc_pkg::ahc_out_t            out_data,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ahc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ahc_pkg::*;

  ahc_cfg_t          cfg;
  ahc_in_t           in_q;
  logic              in_q_valid;
  logic              advance;
  ahc_out_t          res;
  logic [REG_AW-1:0] reg_idx;
  logic              wr_en;

  // config registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_hour        <= '0;
      cfg.wake_minute      <= '0;
      cfg.alarm_enable     <= 1'b0;
      cfg.chime_enable     <= 1'b0;
      cfg.chime_start_hour <= '0;
      cfg.chime_stop_hour  <= CHIME_STOP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALARM_HOUR:       cfg.wake_hour        <= pwdata[4:0];
        REG_ALARM_MINUTE:     cfg.wake_minute      <= pwdata[5:0];
        REG_ALARM_ENABLE:     cfg.alarm_enable     <= pwdata[0];
        REG_CHIME_ENABLE:     cfg.chime_enable     <= pwdata[0];
        REG_CHIME_START_HOUR: cfg.chime_start_hour <= pwdata[4:0];
        REG_CHIME_STOP_HOUR:  cfg.chime_stop_hour  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ALARM_HOUR:       prdata[4:0] = cfg.wake_hour;
      REG_ALARM_MINUTE:     prdata[5:0] = cfg.wake_minute;
      REG_ALARM_ENABLE:     prdata[0]   = cfg.alarm_enable;
      REG_CHIME_ENABLE:     prdata[0]   = cfg.chime_enable;
      REG_CHIME_START_HOUR: prdata[4:0] = cfg.chime_start_hour;
      REG_CHIME_STOP_HOUR:  prdata[4:0] = cfg.chime_stop_hour;
      default: ;
    endcase
  end

  // a held tick moves on when the result register is free or being drained
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // tick input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // sequencer
  ahc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for alarm_and_hourly_chime: random and directed ticks
// on the valid/ready tick channel, configuration over the APB-style port.
// Depends on ahc_pkg and the alarm_and_hourly_chime RTL.
`timescale 1ns / 1ps

module tb;
  import ahc_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat before giving up
  localparam int HOLD_CYCLES  = 80;    // long result-side hold-off
  localparam int MAX_SHOWN    = 10;
  localparam int N_PHASES     = 8;
  localparam int LONG_PH      = 2;     // phase that lets the alarm run out
  localparam int SHORT_ITEMS  = 12;
  localparam int LONG_ITEMS   = 610;
  localparam int IN_W         = $bits(ahc_in_t);
  localparam logic [REG_AW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_AW-1:0] REG_SPARE_B = 3'd7;

  // expected status per tick, from a private copy of the sequencer state
  class tick_status_board;
    ahc_cfg_t    regs;
    ahc_phase_t  alarm_ph;
    ahc_phase_t  chime_ph;
    logic [15:0] alarm_left;
    logic [7:0]  chime_left;
    logic [1:0]  requests;
    ahc_out_t    status_due[$];
    int          n_fail;
    int          n_seen;

    function new();
      regs = '0;
      regs.chime_stop_hour = CHIME_STOP_RESET;
      alarm_ph = PH_ARMED;
      chime_ph = PH_ARMED;
      alarm_left = '0;
      chime_left = '0;
      requests = '0;
      n_fail = 0;
      n_seen = 0;
    endfunction

    function void set_reg(logic [REG_AW-1:0] idx, logic [31:0] v);
      case (idx)
        REG_ALARM_HOUR:       regs.wake_hour = v[4:0];
        REG_ALARM_MINUTE:     regs.wake_minute = v[5:0];
        REG_ALARM_ENABLE:     regs.alarm_enable = v[0];
        REG_CHIME_ENABLE:     regs.chime_enable = v[0];
        REG_CHIME_START_HOUR: regs.chime_start_hour = v[4:0];
        REG_CHIME_STOP_HOUR:  regs.chime_stop_hour = v[4:0];
        default: ;
      endcase
    endfunction

    // inclusive window, wrapping past midnight when start is after stop
    function bit in_chime_window(logic [4:0] h);
      if (regs.chime_start_hour <= regs.chime_stop_hour)
        return regs.chime_start_hour <= h && h <= regs.chime_stop_hour;
      return regs.chime_start_hour <= h || h <= regs.chime_stop_hour;
    endfunction

    function void take_tick(ahc_in_t t);
      bit       skip_chime;
      ahc_out_t st;
      skip_chime = 1'b0;
      // alarm sequencer
      case (alarm_ph)
        PH_RINGING: begin
          if (t.key_pressed) begin
            alarm_ph = PH_DONE;
            alarm_left = '0;
            requests = requests - 2'd1;
            skip_chime = 1'b1;
          end else begin
            if (alarm_left != 0) alarm_left = alarm_left - 16'd1;
            if (alarm_left == 0) begin
              alarm_ph = PH_DONE;
              requests = requests - 2'd1;
            end
          end
        end
        PH_DONE: begin
          if (regs.wake_hour != t.hour_now) alarm_ph = PH_ARMED;
        end
        default: begin
          alarm_ph = PH_ARMED;
          if (regs.alarm_enable && regs.wake_hour == t.hour_now &&
              regs.wake_minute == t.minute_now) begin
            alarm_ph = PH_RINGING;
            alarm_left = ALARM_TICKS;
            requests = requests + 2'd1;
          end
        end
      endcase
      // chime sequencer, held for the tick in which a key silences the alarm
      if (!skip_chime) begin
        case (chime_ph)
          PH_RINGING: begin
            if (chime_left != 0) chime_left = chime_left - 8'd1;
            if (chime_left == 0) begin
              chime_ph = PH_DONE;
              requests = requests - 2'd1;
            end
          end
          PH_DONE: begin
            if (t.minute_now != 0) chime_ph = PH_ARMED;
          end
          default: begin
            chime_ph = PH_ARMED;
            if (regs.chime_enable && t.minute_now == 0 && t.second_now == 0 &&
                in_chime_window(t.hour_now)) begin
              chime_ph = PH_RINGING;
              chime_left = CHIME_TICKS;
              requests = requests + 2'd1;
            end
          end
        endcase
      end
      st.buzzer_on = (requests != 0);
      st.alarm_ringing = (alarm_ph == PH_RINGING);
      st.chime_ringing = (chime_ph == PH_RINGING);
      status_due.push_back(st);
    endfunction

    function void flag_fail(string why);
      n_fail++;
      if (n_fail <= MAX_SHOWN) $display("status beat %0d: %s", n_seen, why);
    endfunction

    function void check_status(ahc_out_t got);
      ahc_out_t want;
      n_seen++;
      if (status_due.size() == 0) begin
        flag_fail($sformatf("unexpected beat buzzer=%b alarm=%b chime=%b",
                            got.buzzer_on, got.alarm_ringing, got.chime_ringing));
        return;
      end
      want = status_due.pop_front();
      if (got.buzzer_on !== want.buzzer_on || got.alarm_ringing !== want.alarm_ringing ||
          got.chime_ringing !== want.chime_ringing)
        flag_fail($sformatf("expected buzzer=%b alarm=%b chime=%b, got %b %b %b",
                            want.buzzer_on, want.alarm_ringing, want.chime_ringing,
                            got.buzzer_on, got.alarm_ringing, got.chime_ringing));
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  ahc_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ahc_out_t             out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  tick_status_board sb;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  bit hold_req = 1'b0;
  int wall_h, wall_m, wall_s;
  int idle_cycles = 0;

  alarm_and_hourly_chime dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // beat monitor: predict on tick beats, check on status beats
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_tick(in_data);
      if (out_valid && out_ready) sb.check_status(out_data);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : status_sink
    int stall;
    forever begin
      if ($urandom_range(0, 29) == 0) quiet_out = !quiet_out;
      stall = quiet_out ? 0 : $urandom_range(0, 17);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_tick(input ahc_in_t t);
    int gap;
    if ($urandom_range(0, 29) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_time(input int h, input int m, input int s, input bit k);
    ahc_in_t t;
    t.hour_now = 5'(h);
    t.minute_now = 6'(m);
    t.second_now = 6'(s);
    t.key_pressed = k;
    send_tick(t);
  endtask

  // stop offering ticks and wait for every status beat
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // setup then access; the bus is released by apb_idle after a batch
  task automatic write_reg(input logic [REG_AW-1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apb_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // field value with junk above the register width
  function automatic logic [31:0] padded(input int v, input int w);
    return ({$urandom} << w) | v;
  endfunction

  function automatic int pick_field(input int legal_hi, input int field_max);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return legal_hi;
      2: return field_max;
      default: return $urandom_range(0, legal_hi);
    endcase
  endfunction

  // move the running clock to the alarm minute or just short of the hour
  function automatic void jump_wall();
    if ($urandom_range(0, 1)) begin
      wall_h = int'(sb.regs.wake_hour);
      wall_m = int'(sb.regs.wake_minute);
      wall_s = $urandom_range(0, 59);
    end else begin
      wall_h = $urandom_range(0, 23);
      wall_m = 59;
      wall_s = $urandom_range(55, 59);
    end
  endfunction

  function automatic void advance_wall(input int secs);
    wall_s += secs;
    while (wall_s >= 60) begin
      wall_s -= 60;
      wall_m++;
    end
    while (wall_m >= 60) begin
      wall_m -= 60;
      wall_h = (wall_h + 1) % 24;
    end
  endfunction

  // mostly a running clock with the odd key, some jumps and some noise
  function automatic ahc_in_t next_tick(input bit keys_ok, input bit steady);
    ahc_in_t t;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      t = IN_W'($urandom);
      if (!keys_ok) t.key_pressed = 1'b0;
      return t;
    end
    if (!steady && r < 18) jump_wall();
    else advance_wall((steady || r < 90) ? 1 : $urandom_range(2, 5));
    t.hour_now = 5'(wall_h);
    t.minute_now = 6'(wall_m);
    t.second_now = 6'(wall_s);
    t.key_pressed = keys_ok && ($urandom_range(0, 11) == 0);
    return t;
  endfunction

  task automatic load_settings(input int ph);
    int ah, am, ae, ce, cs, cp;
    ah = pick_field(23, 31);
    am = pick_field(59, 63);
    ae = int'($urandom_range(0, 3) != 0);
    ce = int'($urandom_range(0, 3) != 0);
    cs = pick_field(23, 31);
    cp = pick_field(23, 31);
    if (ph == 0) begin
      ah = 0; am = 0; ae = 1; ce = 1; cs = 0; cp = 23;
    end
    if (ph == 1) begin
      ah = 23; am = 59; cs = 23; cp = 0;
    end
    if (ph == LONG_PH) begin
      ah = $urandom_range(0, 23); am = 55; ae = 1; ce = 1; cs = 0; cp = 23;
    end
    drain();
    write_reg(REG_ALARM_HOUR, padded(ah, 5));
    write_reg(REG_ALARM_MINUTE, padded(am, 6));
    write_reg(REG_ALARM_ENABLE, padded(ae, 1));
    write_reg(REG_CHIME_ENABLE, padded(ce, 1));
    write_reg(REG_CHIME_START_HOUR, padded(cs, 5));
    write_reg(REG_CHIME_STOP_HOUR, padded(cp, 5));
    apb_idle();
    if (ph == LONG_PH) begin
      wall_h = ah;
      wall_m = am - 1;
      wall_s = 58;
    end else begin
      jump_wall();
    end
  endtask

  initial begin : stimulus
    int ph, n, k;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: alarm and chime both disabled, 0:00 matches nothing
    send_time(0, 0, 0, 0);
    send_time(31, 63, 63, 1);
    send_time(23, 0, 0, 0);

    // alarm at 23:00, chime window 22..2 across midnight, spare addresses poked
    drain();
    write_reg(REG_ALARM_HOUR, padded(23, 5));
    write_reg(REG_ALARM_MINUTE, padded(0, 6));
    write_reg(REG_ALARM_ENABLE, padded(1, 1));
    write_reg(REG_CHIME_ENABLE, padded(1, 1));
    write_reg(REG_CHIME_START_HOUR, padded(22, 5));
    write_reg(REG_CHIME_STOP_HOUR, padded(2, 5));
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    apb_idle();
    send_time(22, 59, 59, 0);
    send_time(23, 0, 0, 0);    // both start together
    send_time(23, 0, 1, 0);
    send_time(23, 0, 2, 1);    // key silences alarm, chime held this tick
    send_time(23, 0, 3, 1);    // key with alarm quiet does nothing
    send_time(23, 1, 0, 0);
    send_time(0, 0, 0, 0);     // alarm re-arms on a new hour
    for (k = 0; k < 16; k++) send_time(1, 5, k, 0);  // chime runs out
    send_time(1, 0, 0, 0);     // done chime stays quiet on minute zero
    send_time(1, 1, 0, 0);
    send_time(2, 0, 0, 0);     // last hour of the window

    // out of range settings still match as raw values
    drain();
    write_reg(REG_ALARM_HOUR, padded(31, 5));
    write_reg(REG_ALARM_MINUTE, padded(63, 6));
    write_reg(REG_CHIME_START_HOUR, padded(5, 5));
    write_reg(REG_CHIME_STOP_HOUR, padded(5, 5));
    apb_idle();
    send_time(31, 63, 0, 0);
    send_time(31, 63, 1, 1);
    send_time(5, 0, 0, 0);

    // random phases, one long enough for the alarm to time out
    for (ph = 0; ph < N_PHASES; ph++) begin
      load_settings(ph);
      n = (ph == LONG_PH) ? LONG_ITEMS : SHORT_ITEMS;
      for (k = 0; k < n; k++) begin
        if (ph == 0 && k == 5) hold_req = 1'b1;
        send_tick(next_tick(ph != LONG_PH, ph == LONG_PH));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== alarm_and_hourly_chime.f =====
hw/rtl/ahc_pkg.sv
hw/rtl/ahc_seq.sv
hw/rtl/alarm_and_hourly_chime.sv
sim/tb.sv
